[hw/rtl/rros_pkg.sv]
`default_nettype none

package rros_pkg;

    localparam int ID_W         = 31;
    localparam int SCORE_W      = 7;
    localparam int TIME_W       = 22;
    localparam int MODE_W       = 2;
    localparam int MAX_ROWS_DEF = 64;

    localparam logic [MODE_W-1:0] MODE_SCORE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TIME    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRETEST = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ALT     = 2'd3;

    typedef struct packed {
        logic              ins;
        logic              shift;
        logic              keyed;
        logic              descending;
        logic [TIME_W-1:0] key;
        logic [ID_W-1:0]   id;
    } cell_ctrl_t;

    function automatic logic [MODE_W-1:0] norm_mode(input logic [MODE_W-1:0] m);
        logic [MODE_W-1:0] r;
        r = (m == MODE_ALT) ? MODE_TIME : m;
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ranked_row_order_sorter_unit.sv]
`default_nettype none

// Ranked row order sorter.
// A request carries one row (row_id, site_score, connect_time_ms, last_row) and is
// taken on a clock edge with start high and busy low. While busy is low, rows are
// taken one per cycle. Each row is placed by a chain of cells: known rows into a
// sorted chain, unknown rows into an arrival-order chain.
// The cycle after the request with last_row, busy rises and the ids stream out,
// one per cycle on ordered_id with strobe high, last_out marking the final one.
// busy falls right after the last id of a set is shown.
// Rows beyond MAX_ROWS are dropped, but a dropped last row still ends the set.
// order_mode is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is always
// high, and the mode is sampled when the first row of a set arrives.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset empties the set, returns to idle and sets order_mode to zero.
module ranked_row_order_sorter_unit #(
    parameter int MAX_ROWS = rros_pkg::MAX_ROWS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [rros_pkg::ID_W-1:0]      row_id,
    input  wire logic [rros_pkg::SCORE_W-1:0]   site_score,
    input  wire logic [rros_pkg::TIME_W-1:0]    connect_time_ms,
    input  wire logic                           last_row,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rros_pkg::MODE_W-1:0]    cfg_data,
    output logic                                strobe,
    output logic [rros_pkg::ID_W-1:0]           ordered_id,
    output logic                                last_out
);

    localparam int CW = $clog2(MAX_ROWS + 1);

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_BEST  = 4'b0010,
        S_KNOWN = 4'b0100,
        S_UNK   = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic [rros_pkg::MODE_W-1:0]   order_mode_reg;
    logic [rros_pkg::MODE_W-1:0]   set_mode_reg, set_mode_next;
    logic [CW-1:0]                 kn_reg, kn_next;
    logic [CW-1:0]                 un_reg, un_next;
    logic [CW-1:0]                 div3_reg, div3_next;
    logic [1:0]                    mod3_reg, mod3_next;
    logic [CW-1:0]                 best_reg, best_next;

    logic                          accept;
    logic [CW-1:0]                 total;
    logic                          first_row;
    logic                          room;
    logic [rros_pkg::MODE_W-1:0]   mode_cur;
    logic [rros_pkg::TIME_W-1:0]   key_val;
    logic                          ins_k;
    logic                          ins_u;
    logic [CW-1:0]                 kn_inc;
    logic [CW-1:0]                 un_inc;
    logic [CW-1:0]                 div3_inc;
    logic [1:0]                    mod3_inc;
    logic [CW-1:0]                 best_cnt;

    rros_pkg::cell_ctrl_t          k_ctrl;
    rros_pkg::cell_ctrl_t          u_ctrl;
    logic [rros_pkg::ID_W-1:0]     k_head;
    logic [rros_pkg::ID_W-1:0]     u_head;

    assign accept    = start && (state_reg == S_LOAD);
    assign total     = kn_reg + un_reg;
    assign first_row = (total == '0);
    assign room      = total < CW'(MAX_ROWS);
    assign mode_cur  = first_row ? rros_pkg::norm_mode(order_mode_reg) : set_mode_reg;
    assign key_val   = (mode_cur == rros_pkg::MODE_SCORE)
                     ? {{(rros_pkg::TIME_W - rros_pkg::SCORE_W){1'b0}}, site_score}
                     : connect_time_ms;
    assign ins_k     = accept && room && (key_val != '0);
    assign ins_u     = accept && room && (key_val == '0);

    assign kn_inc    = ins_k ? kn_reg + CW'(1) : kn_reg;
    assign un_inc    = ins_u ? un_reg + CW'(1) : un_reg;
    assign mod3_inc  = ins_k ? ((mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1) : mod3_reg;
    assign div3_inc  = (ins_k && (mod3_reg == 2'd2)) ? div3_reg + CW'(1) : div3_reg;
    assign best_cnt  = (div3_inc == '0) ? CW'(1) : div3_inc;

    always_comb
    begin
        state_next    = state_reg;
        set_mode_next = set_mode_reg;
        kn_next       = kn_reg;
        un_next       = un_reg;
        div3_next     = div3_reg;
        mod3_next     = mod3_reg;
        best_next     = best_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    kn_next   = kn_inc;
                    un_next   = un_inc;
                    div3_next = div3_inc;
                    mod3_next = mod3_inc;
                    if (first_row)
                    begin
                        set_mode_next = mode_cur;
                    end
                    if (last_row)
                    begin
                        div3_next = '0;
                        mod3_next = '0;
                        best_next = best_cnt;
                        priority if ((mode_cur == rros_pkg::MODE_PRETEST) &&
                                     (kn_inc != '0) && (un_inc != '0))
                        begin
                            state_next = S_BEST;
                        end
                        else if (kn_inc != '0)
                        begin
                            state_next = S_KNOWN;
                        end
                        else
                        begin
                            state_next = S_UNK;
                        end
                    end
                end
            end
            S_BEST:
            begin
                kn_next   = kn_reg - CW'(1);
                best_next = best_reg - CW'(1);
                if (best_reg == CW'(1))
                begin
                    state_next = S_UNK;
                end
            end
            S_KNOWN:
            begin
                kn_next = kn_reg - CW'(1);
                if (kn_reg == CW'(1))
                begin
                    state_next = (un_reg != '0) ? S_UNK : S_LOAD;
                end
            end
            S_UNK:
            begin
                un_next = un_reg - CW'(1);
                if (un_reg == CW'(1))
                begin
                    state_next = (kn_reg != '0) ? S_KNOWN : S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            order_mode_reg <= rros_pkg::MODE_SCORE;
            set_mode_reg   <= rros_pkg::MODE_SCORE;
            kn_reg         <= '0;
            un_reg         <= '0;
            div3_reg       <= '0;
            mod3_reg       <= '0;
            best_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            set_mode_reg <= set_mode_next;
            kn_reg       <= kn_next;
            un_reg       <= un_next;
            div3_reg     <= div3_next;
            mod3_reg     <= mod3_next;
            best_reg     <= best_next;
            if (cfg_valid && cfg_ready)
            begin
                order_mode_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        k_ctrl.ins        = ins_k;
        k_ctrl.shift      = (state_reg == S_BEST) || (state_reg == S_KNOWN);
        k_ctrl.keyed      = 1'b1;
        k_ctrl.descending = (mode_cur == rros_pkg::MODE_SCORE);
        k_ctrl.key        = key_val;
        k_ctrl.id         = row_id;

        u_ctrl.ins        = ins_u;
        u_ctrl.shift      = (state_reg == S_UNK);
        u_ctrl.keyed      = 1'b0;
        u_ctrl.descending = 1'b0;
        u_ctrl.key        = key_val;
        u_ctrl.id         = row_id;
    end

    rros_chain #(
        .DEPTH (MAX_ROWS),
        .CW    (CW)
    ) u_known (
        .clk     (clk),
        .ctrl    (k_ctrl),
        .count   (kn_reg),
        .head_id (k_head)
    );

    rros_chain #(
        .DEPTH (MAX_ROWS),
        .CW    (CW)
    ) u_unknown (
        .clk     (clk),
        .ctrl    (u_ctrl),
        .count   (un_reg),
        .head_id (u_head)
    );

    assign busy       = (state_reg != S_LOAD);
    assign strobe     = (state_reg != S_LOAD);
    assign cfg_ready  = 1'b1;
    assign ordered_id = (state_reg == S_UNK) ? u_head : k_head;
    assign last_out   = strobe && (total == CW'(1));

endmodule

`default_nettype wire

[hw/rtl/rros_cell.sv]
`default_nettype none

module rros_cell (
    input  wire logic                         clk,
    input  wire rros_pkg::cell_ctrl_t         ctrl,
    input  wire logic                         occ,
    input  wire logic                         prev_occ,
    input  wire logic                         prev_take,
    input  wire logic [rros_pkg::TIME_W-1:0]  prev_key,
    input  wire logic [rros_pkg::ID_W-1:0]    prev_id,
    input  wire logic [rros_pkg::TIME_W-1:0]  next_key,
    input  wire logic [rros_pkg::ID_W-1:0]    next_id,
    output logic                              take,
    output logic [rros_pkg::TIME_W-1:0]       key,
    output logic [rros_pkg::ID_W-1:0]         id
);

    logic [rros_pkg::TIME_W-1:0] key_reg;
    logic [rros_pkg::TIME_W-1:0] key_next;
    logic [rros_pkg::ID_W-1:0]   id_reg;
    logic [rros_pkg::ID_W-1:0]   id_next;
    logic                        beats;

    // The new row goes ahead of this entry only on a strict win, which keeps equal keys stable.
    assign beats = ctrl.descending ? (key_reg < ctrl.key) : (key_reg > ctrl.key);
    assign take  = occ ? (ctrl.keyed && beats) : prev_occ;

    always_comb
    begin
        priority if (ctrl.shift)
        begin
            key_next = next_key;
            id_next  = next_id;
        end
        else if (ctrl.ins && prev_take)
        begin
            key_next = prev_key;
            id_next  = prev_id;
        end
        else if (ctrl.ins && take)
        begin
            key_next = ctrl.key;
            id_next  = ctrl.id;
        end
        else
        begin
            key_next = key_reg;
            id_next  = id_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        id_reg  <= id_next;
    end

    assign key = key_reg;
    assign id  = id_reg;

endmodule

`default_nettype wire

[hw/rtl/rros_chain.sv]
`default_nettype none

module rros_chain #(
    parameter int DEPTH = rros_pkg::MAX_ROWS_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                       clk,
    input  wire rros_pkg::cell_ctrl_t       ctrl,
    input  wire logic [CW-1:0]              count,
    output logic [rros_pkg::ID_W-1:0]       head_id
);

    logic [DEPTH-1:0]                occ;
    logic [DEPTH-1:0]                take;
    logic [rros_pkg::TIME_W-1:0]     key_q [DEPTH];
    logic [rros_pkg::ID_W-1:0]       id_q  [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                        p_occ;
        logic                        p_take;
        logic [rros_pkg::TIME_W-1:0] p_key;
        logic [rros_pkg::ID_W-1:0]   p_id;
        logic [rros_pkg::TIME_W-1:0] n_key;
        logic [rros_pkg::ID_W-1:0]   n_id;

        assign occ[i] = CW'(i) < count;

        if (i == 0)
        begin : g_first
            assign p_occ  = 1'b1;
            assign p_take = 1'b0;
            assign p_key  = '0;
            assign p_id   = '0;
        end
        else
        begin : g_mid
            assign p_occ  = occ[i-1];
            assign p_take = take[i-1];
            assign p_key  = key_q[i-1];
            assign p_id   = id_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign n_key = '0;
            assign n_id  = '0;
        end
        else
        begin : g_body
            assign n_key = key_q[i+1];
            assign n_id  = id_q[i+1];
        end

        rros_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occ       (occ[i]),
            .prev_occ  (p_occ),
            .prev_take (p_take),
            .prev_key  (p_key),
            .prev_id   (p_id),
            .next_key  (n_key),
            .next_id   (n_id),
            .take      (take[i]),
            .key       (key_q[i]),
            .id        (id_q[i])
        );
    end

    assign head_id = id_q[0];

endmodule

`default_nettype wire

[hw/rtl/rros_checker.sv]
`default_nettype none

module rros_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic last_row,
    input wire logic strobe,
    input wire logic last_out
);

    // Results stream without gaps for as long as the block reports busy.
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy == strobe)
        else $error("strobe and busy disagree");

    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_row) |=> busy)
        else $error("emission did not follow the final row");

    a_row_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_row) |=> !busy)
        else $error("busy rose without a final row");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_out) |=> !busy)
        else $error("emission continued past the final id");

    a_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(last_out))
        else $error("emission ended without a final id mark");

endmodule

bind ranked_row_order_sorter_unit rros_checker u_rros_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .last_row (last_row),
    .strobe   (strobe),
    .last_out (last_out)
);

`default_nettype wire
